@@ hdl/ccpl_pkg.sv @@
// Shared constants, types and helper functions of the chassis current power limiter.
`default_nettype none
package ccpl_pkg;

  localparam int NUM_LANES = 4;
  localparam int DIV_STEPS = 16;
  localparam int NUM_W     = 36;
  localparam int DEN_W     = 24;
  localparam int ACC_W     = DEN_W + DIV_STEPS;
  localparam int DIV_BASE  = 3;
  localparam int STAGES    = DIV_BASE + DIV_STEPS + 1;

  localparam logic [1:0] REG_ERR_LIMIT = 2'd0;
  localparam logic [1:0] REG_SPEED_CAP = 2'd1;
  localparam logic [1:0] REG_POWER_THR = 2'd2;

  localparam logic [17:0] ERR_LIMIT_RST = 18'd40000;
  localparam logic [14:0] SPEED_CAP_RST = 15'd4096;
  localparam logic [15:0] POWER_THR_RST = 16'd7200;

  typedef struct packed {
    logic [16:0] mag;
    logic        cmd_neg;
    logic [15:0] err_mag;
    logic        err_neg;
  } lane_front_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_op_t;

  // step factor numerator over 20, from buffer energy in joules
  function automatic logic [4:0] step_num(input logic [15:0] energy);
    logic [4:0] pn;
    if (energy < 16'd10) pn = 5'd2;
    else if (energy < 16'd20) pn = 5'd5;
    else if (energy < 16'd30) pn = 5'd6;
    else if (energy < 16'd35) pn = 5'd10;
    else if (energy < 16'd40) pn = 5'd14;
    else if (energy < 16'd50) pn = 5'd16;
    else pn = 5'd20;
    return pn;
  endfunction

  // apply sign; saturate positive results to 32767, negatives are not saturated
  function automatic logic [15:0] sat16(input logic neg, input logic [15:0] q);
    logic [15:0] r;
    if (neg) r = 16'(-q);
    else if (q[15]) r = 16'h7FFF;
    else r = q;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ccpl_if.sv @@
// Channel interfaces: input items, result items and register writes.
`default_nettype none
interface ccpl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cmd_current_0;
  logic signed [15:0] cmd_current_1;
  logic signed [15:0] cmd_current_2;
  logic signed [15:0] cmd_current_3;
  logic signed [15:0] wheel_speed_0;
  logic signed [15:0] wheel_speed_1;
  logic signed [15:0] wheel_speed_2;
  logic signed [15:0] wheel_speed_3;
  logic        [15:0] chassis_power;
  logic        [15:0] buffer_energy;
  modport source(output valid, cmd_current_0, cmd_current_1, cmd_current_2, cmd_current_3,
                 wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
                 chassis_power, buffer_energy, input ready);
  modport sink(input valid, cmd_current_0, cmd_current_1, cmd_current_2, cmd_current_3,
               wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
               chassis_power, buffer_energy, output ready);
endinterface

interface ccpl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] limited_current_0;
  logic signed [15:0] limited_current_1;
  logic signed [15:0] limited_current_2;
  logic signed [15:0] limited_current_3;
  logic               cap_path_taken;
  modport source(output valid, limited_current_0, limited_current_1, limited_current_2,
                 limited_current_3, cap_path_taken, input ready);
  modport sink(input valid, limited_current_0, limited_current_1, limited_current_2,
               limited_current_3, cap_path_taken, output ready);
endinterface

interface ccpl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [17:0] wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

@@ hdl/ccpl_front.sv @@
// One wheel lane front: command magnitude and speed error, registered.
`default_nettype none
module ccpl_front
  import ccpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] cmd,
  input  wire logic [15:0] spd,
  output lane_front_t      front_r
);

  logic signed [16:0] cmd_x;
  logic signed [16:0] err;
  lane_front_t        front_nxt;

  always_comb begin
    cmd_x = {cmd[15], cmd};
    err   = cmd_x - {spd[15], spd};
    front_nxt.cmd_neg = cmd[15];
    front_nxt.mag     = cmd[15] ? 17'(-cmd_x) : cmd_x;
    front_nxt.err_neg = err[16];
    front_nxt.err_mag = err[16] ? 16'(-err) : err[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) front_r <= front_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/ccpl_merge.sv @@
// Merge of the four lanes: peak magnitude, error sum, then divider operands.
`default_nettype none
module ccpl_merge
  import ccpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en_prod,
  input  wire logic        en_oper,
  input  lane_front_t      front [NUM_LANES],
  input  wire logic [4:0]  pn,
  input  wire logic        path_prod,
  input  wire logic [17:0] err_limit,
  input  wire logic [14:0] speed_cap,
  output div_op_t          op_r [NUM_LANES]
);

  logic [16:0] mx_nxt, mx_r;
  logic [17:0] sum_nxt, sum_r;
  logic [31:0] prodc_r [NUM_LANES];
  logic [20:0] prodp_r [NUM_LANES];
  logic [16:0] mag_r [NUM_LANES];
  logic        cneg_r [NUM_LANES];
  logic        eneg_r [NUM_LANES];
  logic [16:0] mx01, mx23;
  logic [17:0] lim, dmax;
  logic [DEN_W-1:0] den20;
  logic        exceed;

  always_comb begin
    mx01 = (front[0].mag > front[1].mag) ? front[0].mag : front[1].mag;
    mx23 = (front[2].mag > front[3].mag) ? front[2].mag : front[3].mag;
    mx_nxt  = (mx01 > mx23) ? mx01 : mx23;
    sum_nxt = 18'(front[0].err_mag) + 18'(front[1].err_mag)
            + 18'(front[2].err_mag) + 18'(front[3].err_mag);
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      mx_r  <= mx_nxt;
      sum_r <= sum_nxt;
      for (int i = 0; i < NUM_LANES; i++) begin
        prodc_r[i] <= 32'(front[i].mag * speed_cap);
        prodp_r[i] <= 21'(front[i].err_mag * pn);
        mag_r[i]   <= front[i].mag;
        cneg_r[i]  <= front[i].cmd_neg;
        eneg_r[i]  <= front[i].err_neg;
      end
    end
  end

  // share = |e| * pn * 32768 / (max(S, L) * 20)
  always_comb begin
    lim    = (err_limit == 18'd0) ? 18'd1 : err_limit;
    dmax   = (sum_r > lim) ? sum_r : lim;
    den20  = {dmax, 4'b0} + {2'b0, dmax, 2'b0} ;
    exceed = mx_r > {2'b0, speed_cap};
  end

  always_ff @(posedge clk) begin
    if (en_oper) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        if (path_prod) begin
          op_r[i].neg <= cneg_r[i];
          op_r[i].num <= exceed ? NUM_W'(prodc_r[i]) : NUM_W'(mag_r[i]);
          op_r[i].den <= exceed ? DEN_W'(mx_r) : DEN_W'(1);
        end else begin
          op_r[i].neg <= eneg_r[i];
          op_r[i].num <= {prodp_r[i], 15'b0};
          op_r[i].den <= den20;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/ccpl_div.sv @@
// Lane divider: one restoring quotient bit per pipeline stage.
`default_nettype none
module ccpl_div
  import ccpl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [DIV_STEPS-1:0] en,
  input  div_op_t                   op,
  output logic [15:0]               quot,
  output logic                      neg
);

  logic [ACC_W-1:0] acc_r [DIV_STEPS];
  logic [DEN_W-1:0] den_r [DIV_STEPS];
  logic             neg_r [DIV_STEPS];
  logic [ACC_W-1:0] acc_in  [DIV_STEPS];
  logic [DEN_W-1:0] den_in  [DIV_STEPS];
  logic [ACC_W-1:0] acc_nxt [DIV_STEPS];
  logic [DEN_W:0]   top     [DIV_STEPS];
  logic [DEN_W:0]   diff    [DIV_STEPS];

  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (s == 0) begin
        acc_in[s] = ACC_W'(op.num);
        den_in[s] = op.den;
      end else begin
        acc_in[s] = acc_r[s-1];
        den_in[s] = den_r[s-1];
      end
      top[s]  = acc_in[s][ACC_W-1:DIV_STEPS-1];
      diff[s] = top[s] - {1'b0, den_in[s]};
      if (!diff[s][DEN_W])
        acc_nxt[s] = {diff[s][DEN_W-1:0], acc_in[s][DIV_STEPS-2:0], 1'b1};
      else
        acc_nxt[s] = {acc_in[s][ACC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (en[s]) begin
        acc_r[s] <= acc_nxt[s];
        den_r[s] <= den_in[s];
        neg_r[s] <= (s == 0) ? op.neg : neg_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign quot = acc_r[DIV_STEPS-1][DIV_STEPS-1:0];
  assign neg  = neg_r[DIV_STEPS-1];

endmodule
`default_nettype wire

@@ hdl/chassis_current_power_limiter.sv @@
// Top level of the chassis current power limiter: lanes, merge, dividers and output register.
//
//  channel  | dir  | handshake         | payload
//  in_ch    | in   | valid / ready     | 4 commanded currents, 4 wheel speeds, power, energy
//  out_ch   | out  | valid / ready     | 4 limited currents, cap_path_taken
//  cfg_ch   | in   | valid / ready = 1 | reg_index, wdata (error limit, speed cap, threshold)
//
// One item is taken per cycle while the pipeline has room; each result passes through
// the front, merge and operand stages, the 16-stage restoring divider in each lane
// and the output stage. Reset (synchronous, rst_n low) empties the pipeline and loads
// the register defaults. A stalled result holds every full stage behind it while
// empty stages still fill; input ready drops only once all 20 stages are full.
`default_nettype none
module chassis_current_power_limiter
  import ccpl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ccpl_in_if.sink    in_ch,
  ccpl_out_if.source out_ch,
  ccpl_cfg_if.sink   cfg_ch
);

  logic [17:0] err_limit_r;
  logic [14:0] speed_cap_r;
  logic [15:0] power_thr_r;

  logic [STAGES-1:0] vld_r, vld_nxt, en;
  logic              path_r [STAGES];
  logic [4:0]        pn_r;

  lane_front_t front [NUM_LANES];
  div_op_t     op    [NUM_LANES];
  logic [15:0] quot  [NUM_LANES];
  logic        qneg  [NUM_LANES];
  logic [15:0] res_r [NUM_LANES];
  logic [15:0] cmd   [NUM_LANES];
  logic [15:0] spd   [NUM_LANES];

  // register writes: always ready, out-of-range indexes dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_limit_r <= ERR_LIMIT_RST;
      speed_cap_r <= SPEED_CAP_RST;
      power_thr_r <= POWER_THR_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_ERR_LIMIT: err_limit_r <= cfg_ch.wdata;
        REG_SPEED_CAP: speed_cap_r <= cfg_ch.wdata[14:0];
        REG_POWER_THR: power_thr_r <= cfg_ch.wdata[15:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage loads when it is empty or its successor advances
  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || out_ch.ready;
    for (int k = STAGES-2; k >= 0; k--) en[k] = !vld_r[k] || en[k+1];
    vld_nxt[0] = en[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < STAGES; k++) vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  // path flag travels alongside each item
  always_ff @(posedge clk) begin
    if (en[0]) begin
      path_r[0] <= in_ch.chassis_power > power_thr_r;
      pn_r      <= step_num(in_ch.buffer_energy);
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) path_r[k] <= path_r[k-1];
    end
  end

  assign cmd[0] = in_ch.cmd_current_0;
  assign cmd[1] = in_ch.cmd_current_1;
  assign cmd[2] = in_ch.cmd_current_2;
  assign cmd[3] = in_ch.cmd_current_3;
  assign spd[0] = in_ch.wheel_speed_0;
  assign spd[1] = in_ch.wheel_speed_1;
  assign spd[2] = in_ch.wheel_speed_2;
  assign spd[3] = in_ch.wheel_speed_3;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_front
    ccpl_front u_front (
      .clk     (clk),
      .en      (en[0]),
      .cmd     (cmd[i]),
      .spd     (spd[i]),
      .front_r (front[i])
    );
  end

  ccpl_merge u_merge (
    .clk       (clk),
    .en_prod   (en[1]),
    .en_oper   (en[2]),
    .front     (front),
    .pn        (pn_r),
    .path_prod (path_r[1]),
    .err_limit (err_limit_r),
    .speed_cap (speed_cap_r),
    .op_r      (op)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_div
    ccpl_div u_div (
      .clk  (clk),
      .en   (en[DIV_BASE +: DIV_STEPS]),
      .op   (op[i]),
      .quot (quot[i]),
      .neg  (qneg[i])
    );
  end

  // output register: apply sign and saturate
  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      for (int i = 0; i < NUM_LANES; i++) res_r[i] <= sat16(qneg[i], quot[i]);
    end
  end

  assign out_ch.valid             = vld_r[STAGES-1];
  assign out_ch.limited_current_0 = res_r[0];
  assign out_ch.limited_current_1 = res_r[1];
  assign out_ch.limited_current_2 = res_r[2];
  assign out_ch.limited_current_3 = res_r[3];
  assign out_ch.cap_path_taken    = path_r[STAGES-1];

endmodule
`default_nettype wire

@@ hdl/ccpl_checker.sv @@
// Port-level checks of the chassis current power limiter, bound to the top level.
`default_nettype none
module ccpl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_data,
  input wire logic        cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output can move");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("register port not ready");

endmodule

bind chassis_current_power_limiter ccpl_checker u_ccpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.limited_current_0, out_ch.limited_current_1,
               out_ch.limited_current_2, out_ch.limited_current_3}),
  .cfg_ready (cfg_ch.ready)
);
`default_nettype wire

@@ verif/ccpl_tb_if.sv @@
// Testbench-side note: channel interfaces come from the RTL; this file holds shared test constants.
`default_nettype none
package ccpl_tb_pkg;
  localparam int PIPE_LATENCY = 20;
endpackage
`default_nettype wire

@@ verif/tb_chassis_current_power_limiter.sv @@
// Self-checking testbench of the chassis current power limiter with a built-in predictor.
`default_nettype none
module tb_chassis_current_power_limiter;
  timeunit 1ns;
  timeprecision 1ps;
  import ccpl_pkg::*;
  import ccpl_tb_pkg::*;

  typedef struct packed {
    logic signed [15:0] l0, l1, l2, l3;
    logic               cap;
  } limited_t;

  typedef struct {
    logic signed [15:0] cmd [4];
    logic signed [15:0] spd [4];
    logic        [15:0] power;
    logic        [15:0] energy;
  } wheel_item_t;

  logic clk;
  logic rst_n;

  ccpl_in_if  in_ch ();
  ccpl_out_if out_ch ();
  ccpl_cfg_if cfg_ch ();

  chassis_current_power_limiter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // predictor's copy of the register file
  logic [17:0] err_limit_q;
  logic [14:0] speed_cap_q;
  logic [15:0] power_thr_q;

  limited_t expected_limits [$];
  int       n_errors;
  int       n_checked;
  int       n_cap;
  bit       idle_enable;
  bit       hold_sink;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("chassis_current_power_limiter: mismatch");
    $finish;
  end

  function automatic logic [15:0] apply_sat(bit neg, longint unsigned q);
    longint r;
    if (neg) r = (q > 32768) ? -32768 : -longint'(q);
    else r = (q > 32767) ? 32767 : longint'(q);
    return r[15:0];
  endfunction

  function automatic longint unsigned energy_step(logic [15:0] e);
    if (e < 10) return 2;
    if (e < 20) return 5;
    if (e < 30) return 6;
    if (e < 35) return 10;
    if (e < 40) return 14;
    if (e < 50) return 16;
    return 20;
  endfunction

  // work out the limited currents for one item
  function automatic limited_t limit_currents(wheel_item_t it);
    limited_t r;
    logic [15:0] o [4];
    longint unsigned m, mx, sum, lim, k, pn, num, den;
    longint e [4];
    mx = 0;
    sum = 0;
    if (it.power > power_thr_q) begin
      for (int i = 0; i < 4; i++) begin
        m = (it.cmd[i] < 0) ? -longint'(it.cmd[i]) : longint'(it.cmd[i]);
        if (m > mx) mx = m;
      end
      for (int i = 0; i < 4; i++) begin
        m = (it.cmd[i] < 0) ? -longint'(it.cmd[i]) : longint'(it.cmd[i]);
        if (mx > speed_cap_q) m = (m * speed_cap_q) / mx;
        o[i] = apply_sat(it.cmd[i] < 0, m);
      end
      r.cap = 1'b1;
    end else begin
      lim = (err_limit_q == 0) ? 1 : err_limit_q;
      pn = energy_step(it.energy);
      for (int i = 0; i < 4; i++) begin
        e[i] = longint'(it.cmd[i]) - longint'(it.spd[i]);
        sum += (e[i] < 0) ? -e[i] : e[i];
      end
      k = (sum < lim) ? sum : lim;
      for (int i = 0; i < 4; i++) begin
        if (sum == 0) o[i] = '0;
        else begin
          m = (e[i] < 0) ? -e[i] : e[i];
          num = m * 32768 * k * pn;
          den = sum * lim * 20;
          o[i] = apply_sat(e[i] < 0, num / den);
        end
      end
      r.cap = 1'b0;
    end
    r.l0 = o[0];
    r.l1 = o[1];
    r.l2 = o[2];
    r.l3 = o[3];
    return r;
  endfunction

  // drop valid for a random burst now and then
  task automatic idle_gap();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // offer one item and hold it until the transfer; valid stays up for the next one
  task automatic send_item(wheel_item_t it);
    idle_gap();
    in_ch.valid         <= 1'b1;
    in_ch.cmd_current_0 <= it.cmd[0];
    in_ch.cmd_current_1 <= it.cmd[1];
    in_ch.cmd_current_2 <= it.cmd[2];
    in_ch.cmd_current_3 <= it.cmd[3];
    in_ch.wheel_speed_0 <= it.spd[0];
    in_ch.wheel_speed_1 <= it.spd[1];
    in_ch.wheel_speed_2 <= it.spd[2];
    in_ch.wheel_speed_3 <= it.spd[3];
    in_ch.chassis_power <= it.power;
    in_ch.buffer_energy <= it.energy;
    do @(posedge clk); while (!in_ch.ready);
    expected_limits.push_back(limit_currents(it));
  endtask

  // stop offering and wait for the pipeline to drain before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_limits.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ERR_LIMIT: err_limit_q = val;
      REG_SPEED_CAP: speed_cap_q = val[14:0];
      REG_POWER_THR: power_thr_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [17:0] lim, logic [14:0] cap, logic [15:0] thr);
    drain();
    write_reg(REG_ERR_LIMIT, lim);
    write_reg(REG_SPEED_CAP, {3'b0, cap});
    write_reg(REG_POWER_THR, {2'b0, thr});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic wheel_item_t rand_item(bit cap_bias);
    wheel_item_t it;
    for (int i = 0; i < 4; i++) begin
      it.cmd[i] = rand_field();
      it.spd[i] = ($urandom_range(0, 7) == 0) ? it.cmd[i] : rand_field();
    end
    if ($urandom_range(0, 9) == 0) it.power = 16'($urandom());
    else if (cap_bias) it.power = 16'(power_thr_q + $urandom_range(1, 200));
    else it.power = 16'($urandom_range(0, power_thr_q));
    it.energy = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 60));
    return it;
  endfunction

  // check each transferred result against the oldest prediction
  always @(posedge clk) begin
    limited_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.limited_current_0, out_ch.limited_current_1, out_ch.limited_current_2,
             out_ch.limited_current_3, out_ch.cap_path_taken};
      if (expected_limits.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        n_errors++;
      end else begin
        want = expected_limits.pop_front();
        n_checked++;
        if (got.cap) n_cap++;
        if (got.l0 !== want.l0) begin
          $display("%0t: limited_current_0 exp %0d got %0d", $time, want.l0, got.l0);
          n_errors++;
        end
        if (got.l1 !== want.l1) begin
          $display("%0t: limited_current_1 exp %0d got %0d", $time, want.l1, got.l1);
          n_errors++;
        end
        if (got.l2 !== want.l2) begin
          $display("%0t: limited_current_2 exp %0d got %0d", $time, want.l2, got.l2);
          n_errors++;
        end
        if (got.l3 !== want.l3) begin
          $display("%0t: limited_current_3 exp %0d got %0d", $time, want.l3, got.l3);
          n_errors++;
        end
        if (got.cap !== want.cap) begin
          $display("%0t: cap_path_taken exp %0b got %0b", $time, want.cap, got.cap);
          n_errors++;
        end
      end
    end
  end

  // result-side ready: random bursts of back-pressure, or a long hold when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) out_ch.ready <= 1'b0;
      else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk);
      end else out_ch.ready <= 1'b1;
    end
  end

  task automatic test_directed();
    wheel_item_t it;
    logic signed [15:0] edges [4] = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1};
    // zero error sum
    for (int i = 0; i < 4; i++) begin
      it.cmd[i] = 16'sd1234;
      it.spd[i] = 16'sd1234;
    end
    it.power = 16'd0;
    it.energy = 16'd100;
    send_item(it);
    // single full-scale error: +32768 saturates, -32768 at the other sign
    it.cmd = '{16'sh7FFF, 0, 0, 0};
    it.spd = '{16'sh8000, 0, 0, 0};
    send_item(it);
    it.cmd = '{16'sh8000, 0, 0, 0};
    it.spd = '{16'sd1, 0, 0, 0};
    send_item(it);
    // step factor at buffer energies from 5 to 54 in steps of 7, which skip the 35 to 39 band
    foreach (edges[j]) ;
    for (int e = 0; e < 8; e++) begin
      it.cmd = '{16'sd3000, -16'sd2000, 16'sd500, 16'sh8000};
      it.spd = '{16'sd0, 16'sd100, 16'sh7FFF, 16'sd0};
      it.energy = 16'(e * 7 + 5);
      send_item(it);
    end
    // cap path: exceeded with -32768, not exceeded, power at and one over threshold
    it.power = 16'hFFFF;
    it.cmd = '{16'sh8000, 16'sh7FFF, 16'sd100, -16'sd5000};
    send_item(it);
    it.cmd = '{16'sd10, -16'sd20, 16'sd4096, -16'sd4096};
    send_item(it);
    it.power = 16'(power_thr_q);
    send_item(it);
    it.power = 16'(power_thr_q + 1);
    send_item(it);
    for (int i = 0; i < 4; i++) it.cmd[i] = edges[i];
    it.spd = edges;
    it.power = 16'd0;
    send_item(it);
  endtask

  task automatic test_random(int count, bit cap_bias);
    for (int n = 0; n < count; n++) send_item(rand_item(cap_bias ? $urandom_range(0, 1) : 0));
  endtask

  // stall the result side for a long stretch so the pipeline fills
  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (60) @(posedge clk);
        hold_sink = 1'b0;
      end
      test_random(50, 1);
    join
    // pause the sender until everything has come back
    drain();
  endtask

  initial begin
    n_errors = 0;
    n_checked = 0;
    n_cap = 0;
    idle_enable = 1'b1;
    hold_sink = 1'b0;
    err_limit_q = ERR_LIMIT_RST;
    speed_cap_q = SPEED_CAP_RST;
    power_thr_q = POWER_THR_RST;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd_current_0 <= '0;
    in_ch.cmd_current_1 <= '0;
    in_ch.cmd_current_2 <= '0;
    in_ch.cmd_current_3 <= '0;
    in_ch.wheel_speed_0 <= '0;
    in_ch.wheel_speed_1 <= '0;
    in_ch.wheel_speed_2 <= '0;
    in_ch.wheel_speed_3 <= '0;
    in_ch.chassis_power <= '0;
    in_ch.buffer_energy <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_ERR_LIMIT;
    cfg_ch.wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200, 1);
    test_backpressure();
    set_regs(18'd1, 15'd1, 16'd0);
    test_random(150, 1);
    set_regs(18'd262140, 15'd32767, 16'd65535);
    test_random(150, 0);
    set_regs(18'd0, 15'd0, 16'd100);
    test_random(150, 1);
    set_regs(18'($urandom_range(1, 262140)), 15'($urandom_range(1, 32767)), 16'($urandom()));
    test_random(200, 1);
    set_regs(ERR_LIMIT_RST, SPEED_CAP_RST, POWER_THR_RST);
    // final stretch with no idling on either side
    idle_enable = 1'b0;
    test_random(200, 1);

    drain();
    $display("covered %0d results (%0d via cap path) over six register settings",
             n_checked, n_cap);
    if (n_errors == 0 && expected_limits.size() == 0) begin
      $display("chassis_current_power_limiter: match");
    end else begin
      $display("chassis_current_power_limiter: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
